### hw/rtl/scg_pkg.sv
// ----------------------------------------------------------------------------
// scg_pkg
// Register indexes, reset values and shared types of the shore clearance guard.
// ----------------------------------------------------------------------------
package scg_pkg;

	localparam int unsigned REG_BITS  = 16;
	localparam int unsigned IDX_BITS  = 3;

	typedef enum logic [IDX_BITS-1:0] {
		REG_SLOW_DIST   = 3'd0,
		REG_SLOW_HYST   = 3'd1,
		REG_BREACH_DIST = 3'd2,
		REG_CRUMB_DIST  = 3'd3,
		REG_CRUMB_SPACE = 3'd4,
		REG_ARRIVE_DIST = 3'd5
	} reg_index_t;

	localparam logic [REG_BITS-1:0] RST_SLOW_DIST   = 16'd250;
	localparam logic [REG_BITS-1:0] RST_SLOW_HYST   = 16'd80;
	localparam logic [REG_BITS-1:0] RST_BREACH_DIST = 16'd30;
	localparam logic [REG_BITS-1:0] RST_CRUMB_DIST  = 16'd200;
	localparam logic [REG_BITS-1:0] RST_CRUMB_SPACE = 16'd100;
	localparam logic [REG_BITS-1:0] RST_ARRIVE_DIST = 16'd80;

	// raise applied to the breach distance when the crumb distance is not above it
	localparam logic [REG_BITS:0] CRUMB_RAISE = 17'd100;

	// thresholds as seen by the datapath, some of them precomputed
	typedef struct packed {
		logic [REG_BITS-1:0]   slow_thr;
		logic [REG_BITS:0]     slow_clear;
		logic [REG_BITS-1:0]   breach_thr;
		logic [REG_BITS:0]     crumb_lim;
		logic [REG_BITS-1:0]   spacing;
		logic [2*REG_BITS-1:0] spacing_sq;
		logic [REG_BITS-1:0]   arrive;
		logic [2*REG_BITS-1:0] arrive_sq;
	} thresh_t;

endpackage

### hw/rtl/shore_clearance_guard.sv
// ----------------------------------------------------------------------------
// shore_clearance_guard
// Breadcrumb, slow and breach supervision of navigation updates near land.
// ----------------------------------------------------------------------------
// Each accepted navigation update yields exactly one result. An update is
// captured in an input register, evaluated against the current crumb and
// flags, and written to the result register; one update can be taken every
// cycle while the result channel is not stalled. The rate is set by the
// single distance test (two 16 x 16 squarers and a compare) between the input
// and result registers. While a result is held by out_stall, one more update
// is captured and then in_stall rises. A register write reaches the derived
// thresholds through a second register in scg_cfg.
// ----------------------------------------------------------------------------
module shore_clearance_guard
	import scg_pkg::*;
#(
	parameter int unsigned COORD_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [IDX_BITS-1:0]          cfg_index,
	input  logic [REG_BITS-1:0]          cfg_data,
	// update channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic [REG_BITS-1:0]          clearance,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         slow_flag,
	output logic                         breach_flag,
	output logic                         slow_changed,
	output logic                         breach_changed,
	output logic                         breach_refused,
	output logic                         escape_valid,
	output logic                         escape_posted,
	output logic signed [COORD_BITS-1:0] escape_x,
	output logic signed [COORD_BITS-1:0] escape_y
);

	thresh_t thresh;

	scg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thresh    (thresh)
	);

	// input stage
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] pos_x_s1;
	logic signed [COORD_BITS-1:0] pos_y_s1;
	logic [REG_BITS-1:0]          clr_s1;
	logic                         advance;
	logic                         in_xfer;

	// guard state
	logic                         slow_q;
	logic                         breach_q;
	logic                         crumb_valid_q;
	logic signed [COORD_BITS-1:0] crumb_x_q;
	logic signed [COORD_BITS-1:0] crumb_y_q;

	// result register
	logic                         out_valid_q;
	logic                         slow_flag_q;
	logic                         breach_flag_q;
	logic                         slow_changed_q;
	logic                         breach_changed_q;
	logic                         refused_q;
	logic                         escape_valid_q;
	logic                         posted_q;
	logic signed [COORD_BITS-1:0] escape_x_q;
	logic signed [COORD_BITS-1:0] escape_y_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			clr_s1   <= clearance;
		end
	end

	// one distance test serves both uses: spacing when calm, arrival during breach
	logic [REG_BITS-1:0]   lim;
	logic [2*REG_BITS-1:0] lim_sq;
	logic                  near;

	assign lim    = breach_q ? thresh.arrive    : thresh.spacing;
	assign lim_sq = breach_q ? thresh.arrive_sq : thresh.spacing_sq;

	scg_near #(
		.COORD_BITS (COORD_BITS)
	) u_near (
		.ax     (pos_x_s1),
		.ay     (pos_y_s1),
		.bx     (crumb_x_q),
		.by     (crumb_y_q),
		.lim    (lim),
		.lim_sq (lim_sq),
		.near   (near)
	);

	logic                         clr_ok;
	logic                         lay;
	logic                         crumb_valid_d;
	logic                         slow_d;
	logic                         below;
	logic                         breach_end;
	logic                         breach_d;
	logic                         refused_d;
	logic                         posted_d;
	logic signed [COORD_BITS-1:0] crumb_x_d;
	logic signed [COORD_BITS-1:0] crumb_y_d;

	always_comb begin
		clr_ok        = {1'b0, clr_s1} >= thresh.crumb_lim;
		lay           = clr_ok && !breach_q && (!crumb_valid_q || !near);
		crumb_valid_d = crumb_valid_q || lay;
		crumb_x_d     = lay ? pos_x_s1 : crumb_x_q;
		crumb_y_d     = lay ? pos_y_s1 : crumb_y_q;

		if (!slow_q) begin
			slow_d = clr_s1 < thresh.slow_thr;
		end else begin
			slow_d = !({1'b0, clr_s1} > thresh.slow_clear);
		end

		below      = clr_s1 < thresh.breach_thr;
		breach_end = near || clr_ok;
		if (!breach_q) begin
			breach_d  = below && crumb_valid_d;
			refused_d = below && !crumb_valid_d;
			posted_d  = lay;
		end else begin
			breach_d  = !breach_end;
			refused_d = 1'b0;
			posted_d  = !breach_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q        <= 1'b0;
			breach_q      <= 1'b0;
			crumb_valid_q <= 1'b0;
			crumb_x_q     <= '0;
			crumb_y_q     <= '0;
		end else if (advance) begin
			slow_q        <= slow_d;
			breach_q      <= breach_d;
			crumb_valid_q <= crumb_valid_d;
			crumb_x_q     <= crumb_x_d;
			crumb_y_q     <= crumb_y_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slow_flag_q      <= slow_d;
			breach_flag_q    <= breach_d;
			slow_changed_q   <= slow_d ^ slow_q;
			breach_changed_q <= breach_d ^ breach_q;
			refused_q        <= refused_d;
			escape_valid_q   <= crumb_valid_d;
			posted_q         <= posted_d;
			escape_x_q       <= crumb_x_d;
			escape_y_q       <= crumb_y_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign slow_flag      = slow_flag_q;
	assign breach_flag    = breach_flag_q;
	assign slow_changed   = slow_changed_q;
	assign breach_changed = breach_changed_q;
	assign breach_refused = refused_q;
	assign escape_valid   = escape_valid_q;
	assign escape_posted  = posted_q;
	assign escape_x       = escape_x_q;
	assign escape_y       = escape_y_q;

	// a breach always has an escape point behind it
	a_breach_has_crumb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && breach_flag |-> escape_valid)
		else $error("breach reported without an escape point");

	// a refusal only happens with no crumb and no breach
	a_refusal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && breach_refused |-> !escape_valid && !breach_flag && !breach_changed)
		else $error("refusal reported with a crumb or a breach");

	// the update that starts a breach neither lays nor reposts a crumb
	a_breach_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && breach_changed && breach_flag |-> !escape_posted)
		else $error("escape posted on the update that started a breach");

	// guard state moves only when an update passes to the result register
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(crumb_valid_q) && $stable(breach_q) && $stable(crumb_x_q))
		else $error("guard state changed without an update");

endmodule

### hw/rtl/scg_cfg.sv
// ----------------------------------------------------------------------------
// scg_cfg
// Configuration registers and the thresholds derived from them.
// ----------------------------------------------------------------------------
module scg_cfg
	import scg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0] cfg_data,
	output thresh_t             thresh
);

	logic [REG_BITS-1:0]   slow_thr_q;
	logic [REG_BITS-1:0]   slow_hyst_q;
	logic [REG_BITS-1:0]   breach_thr_q;
	logic [REG_BITS-1:0]   crumb_dist_q;
	logic [REG_BITS-1:0]   spacing_q;
	logic [REG_BITS-1:0]   arrive_q;
	logic [REG_BITS:0]     slow_clear_q;
	logic [REG_BITS:0]     crumb_lim_q;
	logic [2*REG_BITS-1:0] spacing_sq_q;
	logic [2*REG_BITS-1:0] arrive_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_thr_q    <= RST_SLOW_DIST;
			slow_hyst_q   <= RST_SLOW_HYST;
			breach_thr_q  <= RST_BREACH_DIST;
			crumb_dist_q  <= RST_CRUMB_DIST;
			spacing_q     <= RST_CRUMB_SPACE;
			arrive_q      <= RST_ARRIVE_DIST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SLOW_DIST:   slow_thr_q    <= cfg_data;
				REG_SLOW_HYST:   slow_hyst_q   <= cfg_data;
				REG_BREACH_DIST: breach_thr_q  <= cfg_data;
				REG_CRUMB_DIST:  crumb_dist_q  <= cfg_data;
				REG_CRUMB_SPACE: spacing_q     <= cfg_data;
				REG_ARRIVE_DIST: arrive_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// derived values are registered again from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_clear_q <= {1'b0, RST_SLOW_DIST} + {1'b0, RST_SLOW_HYST};
			crumb_lim_q  <= {1'b0, RST_CRUMB_DIST};
			spacing_sq_q <= 32'(RST_CRUMB_SPACE) * 32'(RST_CRUMB_SPACE);
			arrive_sq_q  <= 32'(RST_ARRIVE_DIST) * 32'(RST_ARRIVE_DIST);
		end else begin
			slow_clear_q <= {1'b0, slow_thr_q} + {1'b0, slow_hyst_q};
			if (crumb_dist_q <= breach_thr_q) begin
				crumb_lim_q <= {1'b0, breach_thr_q} + CRUMB_RAISE;
			end else begin
				crumb_lim_q <= {1'b0, crumb_dist_q};
			end
			spacing_sq_q <= 32'(spacing_q) * 32'(spacing_q);
			arrive_sq_q  <= 32'(arrive_q) * 32'(arrive_q);
		end
	end

	assign thresh.slow_thr    = slow_thr_q;
	assign thresh.slow_clear  = slow_clear_q;
	assign thresh.breach_thr  = breach_thr_q;
	assign thresh.crumb_lim   = crumb_lim_q;
	assign thresh.spacing     = spacing_q;
	assign thresh.spacing_sq  = spacing_sq_q;
	assign thresh.arrive      = arrive_q;
	assign thresh.arrive_sq   = arrive_sq_q;

endmodule

### hw/rtl/scg_near.sv
// ----------------------------------------------------------------------------
// scg_near
// Tests whether two points lie strictly closer than a limit, by squared length.
// ----------------------------------------------------------------------------
module scg_near
	import scg_pkg::*;
#(
	parameter int unsigned COORD_BITS = 18
) (
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	input  logic        [REG_BITS-1:0]   lim,
	input  logic        [2*REG_BITS-1:0] lim_sq,
	output logic                         near
);

	localparam int unsigned DW = (COORD_BITS + 1 > REG_BITS) ? COORD_BITS + 1 : REG_BITS + 1;

	logic signed [DW-1:0]    diff_x;
	logic signed [DW-1:0]    diff_y;
	logic        [DW-1:0]    dx;
	logic        [DW-1:0]    dy;
	logic        [DW-1:0]    lim_w;
	logic                    far;
	logic [2*REG_BITS-1:0]   sq_x;
	logic [2*REG_BITS-1:0]   sq_y;
	logic [2*REG_BITS:0]     sum;

	assign diff_x = DW'(ax) - DW'(bx);
	assign diff_y = DW'(ay) - DW'(by);
	assign dx     = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
	assign dy     = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
	assign lim_w  = DW'(lim);

	// an axis offset at or beyond the limit settles the answer; otherwise both fit 16 bits
	assign far  = (dx >= lim_w) || (dy >= lim_w);
	assign sq_x = dx[REG_BITS-1:0] * dx[REG_BITS-1:0];
	assign sq_y = dy[REG_BITS-1:0] * dy[REG_BITS-1:0];
	assign sum  = {1'b0, sq_x} + {1'b0, sq_y};
	assign near = !far && (sum < {1'b0, lim_sq});

endmodule
